FILE: rtl/core/joint_impedance_torque_step_macros.svh
// Assertion macros shared by the block's RTL.
// Simulation builds get checking properties; synthesis builds get nothing.
`ifndef JOINT_IMPEDANCE_TORQUE_STEP_MACROS_SVH
`define JOINT_IMPEDANCE_TORQUE_STEP_MACROS_SVH

`ifndef SYNTHESIS

`define JITS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

`define JITS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`else

`define JITS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`define JITS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/core/jits_pkg.sv
package jits_pkg;

	localparam int MUL_A_W = 18;
	localparam int MUL_B_W = 17;
	localparam int ACC_W   = 36;

	typedef struct packed {
		logic signed [15:0] vel;
		logic signed [15:0] tgt;
	} state_word_t;

	typedef struct packed {
		logic en;
		logic accum;
	} mac_ctrl_t;

	localparam logic [2:0] REG_STIFF_LO  = 3'd0;
	localparam logic [2:0] REG_STIFF_HI  = 3'd1;
	localparam logic [2:0] REG_DAMP_LO   = 3'd2;
	localparam logic [2:0] REG_DAMP_HI   = 3'd3;
	localparam logic [2:0] REG_MAX_ERR   = 3'd4;
	localparam logic [2:0] REG_STEP_LIM  = 3'd5;
	localparam logic [2:0] REG_VEL_ALPHA = 3'd6;
	localparam logic [2:0] REG_TGT_ALPHA = 3'd7;

	localparam logic [63:0] RST_STIFF_LO  = 64'h2580_2580_2580_2580;
	localparam logic [47:0] RST_STIFF_HI  = 48'h0320_0960_0FA0;
	localparam logic [63:0] RST_DAMP_LO   = 64'h0320_0320_0320_0320;
	localparam logic [47:0] RST_DAMP_HI   = 48'h00F0_0190_01E0;
	localparam logic [14:0] RST_MAX_ERR   = 15'd819;
	localparam logic [14:0] RST_STEP_LIM  = 15'd64;
	localparam logic [15:0] RST_VEL_ALPHA = 16'd64881;
	localparam logic [15:0] RST_TGT_ALPHA = 16'd62259;

	localparam logic signed [ACC_W-1:0] RND16 = 36'sd32768;
	localparam logic signed [ACC_W-1:0] RND10 = 36'sd512;

endpackage

FILE: rtl/core/jits_state_mem.sv
module jits_state_mem #(
	parameter int DEPTH = 7,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output jits_pkg::state_word_t rd_data,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  jits_pkg::state_word_t wr_data
);
	import jits_pkg::*;

	// Entries that were never written since reset read as zero.
	state_word_t mem [DEPTH];
	state_word_t rdata_q;
	logic        rvld_q;
	logic [DEPTH-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
			rvld_q  <= vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_data = rvld_q ? rdata_q : '0;

endmodule

FILE: rtl/core/jits_mac.sv
module jits_mac (
	input  logic                                 clk,
	input  jits_pkg::mac_ctrl_t                  ctrl,
	input  logic signed [jits_pkg::MUL_A_W-1:0]  mul_a,
	input  logic signed [jits_pkg::MUL_B_W-1:0]  mul_b,
	output logic signed [jits_pkg::ACC_W-1:0]    acc
);
	import jits_pkg::*;

	logic signed [MUL_A_W+MUL_B_W-1:0] prod;
	logic signed [ACC_W-1:0]           acc_q;

	assign prod = mul_a * mul_b;

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			acc_q <= ctrl.accum ? acc_q + ACC_W'(prod) : ACC_W'(prod);
		end
	end

	assign acc = acc_q;

endmodule

FILE: rtl/core/joint_impedance_torque_step.sv
// Joint impedance torque step with torque rate limit.
// Input words carry one joint sample; each accepted input word yields exactly
// one output word (joint index, torque command, clip flag), in order.
// Both channels use valid/stall; a word moves when valid is high and stall low.
// A control update steps through states V0, V1, T0, T1, D, CLIP, K and TAU:
// one shared 18x17 multiply-accumulate unit runs six products in sequence, and
// the per-joint filter state is read from and written back to one small memory.
// Start commands and out-of-range joints go straight to the output state S_OUT.
// One word is in flight at a time, so no new input word is taken until the
// current one has left the output state. The input is taken while a finished
// output word still waits, and the block holds in its last step while the
// output register is occupied and stalled. A stalled output word holds its value.
// Reset clears the filter state of every joint to zero and loads the default
// gains, limits and filter weights. Configuration writes take effect at once;
// the user must make them only while no word is in flight, unchecked by the block.
`include "joint_impedance_torque_step_macros.svh"

module joint_impedance_torque_step #(
	parameter int NUM_JOINTS = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [2:0]         cfg_idx,
	input  logic [63:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic [2:0]         joint,
	input  logic signed [15:0] pos_meas,
	input  logic signed [15:0] vel_meas,
	input  logic signed [15:0] pos_goal,
	input  logic signed [15:0] vel_goal,
	input  logic signed [15:0] coriolis_torque,
	input  logic signed [15:0] torque_last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         joint_out,
	output logic signed [15:0] torque_cmd,
	output logic               error_clipped
);
	import jits_pkg::*;

	localparam int AW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_V0   = 4'd1;
	localparam logic [3:0] S_V1   = 4'd2;
	localparam logic [3:0] S_T0   = 4'd3;
	localparam logic [3:0] S_T1   = 4'd4;
	localparam logic [3:0] S_D    = 4'd5;
	localparam logic [3:0] S_CLIP = 4'd6;
	localparam logic [3:0] S_K    = 4'd7;
	localparam logic [3:0] S_TAU  = 4'd8;
	localparam logic [3:0] S_OUT  = 4'd9;

	function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
		if (v > 36'sd32767) begin
			return 16'sh7FFF;
		end else if (v < -36'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	function automatic logic [15:0] gain_of(input logic [63:0] lo, input logic [47:0] hi,
			input logic [2:0] j);
		case (j)
			3'd0: return lo[15:0];
			3'd1: return lo[31:16];
			3'd2: return lo[47:32];
			3'd3: return lo[63:48];
			3'd4: return hi[15:0];
			3'd5: return hi[31:16];
			3'd6: return hi[47:32];
			default: return 16'd0;
		endcase
	endfunction

	logic [63:0] stiff_lo_q;
	logic [47:0] stiff_hi_q;
	logic [63:0] damp_lo_q;
	logic [47:0] damp_hi_q;
	logic [14:0] max_err_q;
	logic [14:0] step_lim_q;
	logic [15:0] vel_alpha_q;
	logic [15:0] tgt_alpha_q;

	logic [3:0] state_q;
	logic       out_valid_q;

	logic [2:0]         joint_q;
	logic signed [15:0] pos_q;
	logic signed [15:0] vel_q;
	logic signed [15:0] goal_q;
	logic signed [15:0] vgoal_q;
	logic signed [15:0] cor_q;
	logic signed [15:0] last_q;
	logic               byp_q;
	logic               clipped_q;
	logic signed [15:0] vf_q;
	logic signed [16:0] verr_q;
	logic signed [15:0] tg_q;
	logic signed [16:0] err_q;
	logic signed [26:0] tau_q;

	logic [2:0]         joint_out_q;
	logic signed [15:0] torque_q;
	logic               clip_out_q;

	logic in_acc;
	logic in_range;
	logic out_load;

	state_word_t rd_data;
	state_word_t wr_data;
	logic        mem_re;
	logic        mem_we;
	logic [AW-1:0] wr_addr;

	mac_ctrl_t                 mac_ctrl;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [ACC_W-1:0]   acc;

	logic signed [ACC_W-1:0] acc_sh16;
	logic signed [ACC_W-1:0] acc_sh10;

	logic signed [17:0] err0;
	logic signed [17:0] me18;
	logic signed [17:0] tcl;
	logic signed [17:0] errf;
	logic signed [15:0] tgf;
	logic               over;

	logic signed [27:0] lim28;
	logic signed [27:0] diff;
	logic signed [27:0] dcl;
	logic signed [27:0] sum28;
	logic signed [15:0] res;
	logic signed [27:0] res_delta;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign in_range = (32'(joint) < NUM_JOINTS);
	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiff_lo_q  <= RST_STIFF_LO;
			stiff_hi_q  <= RST_STIFF_HI;
			damp_lo_q   <= RST_DAMP_LO;
			damp_hi_q   <= RST_DAMP_HI;
			max_err_q   <= RST_MAX_ERR;
			step_lim_q  <= RST_STEP_LIM;
			vel_alpha_q <= RST_VEL_ALPHA;
			tgt_alpha_q <= RST_TGT_ALPHA;
		end else if (cfg_wen) begin
			case (cfg_idx)
				REG_STIFF_LO:  stiff_lo_q  <= cfg_wdata;
				REG_STIFF_HI:  stiff_hi_q  <= cfg_wdata[47:0];
				REG_DAMP_LO:   damp_lo_q   <= cfg_wdata;
				REG_DAMP_HI:   damp_hi_q   <= cfg_wdata[47:0];
				REG_MAX_ERR:   max_err_q   <= cfg_wdata[14:0];
				REG_STEP_LIM:  step_lim_q  <= cfg_wdata[14:0];
				REG_VEL_ALPHA: vel_alpha_q <= cfg_wdata[15:0];
				REG_TGT_ALPHA: tgt_alpha_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= (in_range && !cmd) ? S_V0 : S_OUT;
					end
				end
				S_V0:   state_q <= S_V1;
				S_V1:   state_q <= S_T0;
				S_T0:   state_q <= S_T1;
				S_T1:   state_q <= S_D;
				S_D:    state_q <= S_CLIP;
				S_CLIP: state_q <= S_K;
				S_K:    state_q <= S_TAU;
				S_TAU:  state_q <= S_OUT;
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign mem_re  = in_acc && in_range && !cmd;
	assign mem_we  = (in_acc && in_range && cmd) || (state_q == S_CLIP);
	assign wr_addr = (state_q == S_CLIP) ? AW'(joint_q) : AW'(joint);

	always_comb begin
		if (state_q == S_CLIP) begin
			wr_data.vel = vf_q;
			wr_data.tgt = tgf;
		end else begin
			wr_data.vel = '0;
			wr_data.tgt = pos_meas;
		end
	end

	jits_state_mem #(
		.DEPTH(NUM_JOINTS)
	) u_state_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (mem_re),
		.rd_addr (AW'(joint)),
		.rd_data (rd_data),
		.wr_en   (mem_we),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	always_comb begin
		mac_ctrl.en    = 1'b0;
		mac_ctrl.accum = 1'b0;
		mul_a          = '0;
		mul_b          = '0;
		case (state_q)
			S_V0: begin
				mac_ctrl.en = 1'b1;
				mul_a = MUL_A_W'(18'sd65536 - $signed({2'b00, vel_alpha_q}));
				mul_b = MUL_B_W'(rd_data.vel);
			end
			S_V1: begin
				mac_ctrl.en    = 1'b1;
				mac_ctrl.accum = 1'b1;
				mul_a = $signed({2'b00, vel_alpha_q});
				mul_b = MUL_B_W'(vel_q);
			end
			S_T0: begin
				mac_ctrl.en = 1'b1;
				mul_a = $signed({2'b00, tgt_alpha_q});
				mul_b = MUL_B_W'(rd_data.tgt);
			end
			S_T1: begin
				mac_ctrl.en    = 1'b1;
				mac_ctrl.accum = 1'b1;
				mul_a = MUL_A_W'(18'sd65536 - $signed({2'b00, tgt_alpha_q}));
				mul_b = MUL_B_W'(goal_q);
			end
			S_D: begin
				mac_ctrl.en = 1'b1;
				mul_a = $signed({2'b00, gain_of(damp_lo_q, damp_hi_q, joint_q)});
				mul_b = verr_q;
			end
			S_K: begin
				mac_ctrl.en    = 1'b1;
				mac_ctrl.accum = 1'b1;
				mul_a = $signed({2'b00, gain_of(stiff_lo_q, stiff_hi_q, joint_q)});
				mul_b = err_q;
			end
			default: ;
		endcase
	end

	jits_mac u_mac (
		.clk   (clk),
		.ctrl  (mac_ctrl),
		.mul_a (mul_a),
		.mul_b (mul_b),
		.acc   (acc)
	);

	assign acc_sh16 = (acc + RND16) >>> 16;
	assign acc_sh10 = (acc + RND10) >>> 10;

	// The target is pulled back to within max_error of the measured position.
	assign err0 = 18'(tg_q) - 18'(pos_q);
	assign me18 = $signed({3'b000, max_err_q});
	assign over = (err0 > me18) || (-err0 > me18);
	assign tcl  = (err0 < 18'sd0) ? 18'(pos_q) - me18 : 18'(pos_q) + me18;
	assign tgf  = over ? sat16(ACC_W'(tcl)) : tg_q;
	assign errf = 18'(tgf) - 18'(pos_q);

	assign lim28 = $signed({13'd0, step_lim_q});
	assign diff  = 28'(tau_q) - 28'(last_q);
	assign dcl   = (diff > lim28) ? lim28 : ((diff < -lim28) ? -lim28 : diff);
	assign sum28 = 28'(last_q) + dcl;
	assign res   = byp_q ? last_q : sat16(ACC_W'(sum28));
	assign res_delta = 28'(res) - 28'(last_q);

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					joint_q   <= joint;
					pos_q     <= pos_meas;
					vel_q     <= vel_meas;
					goal_q    <= pos_goal;
					vgoal_q   <= vel_goal;
					cor_q     <= coriolis_torque;
					last_q    <= torque_last;
					byp_q     <= !(in_range && !cmd);
					clipped_q <= 1'b0;
				end
			end
			S_T0: vf_q <= sat16(acc_sh16);
			S_T1: verr_q <= 17'(vgoal_q) - 17'(vf_q);
			S_D: tg_q <= sat16(acc_sh16);
			S_CLIP: begin
				err_q     <= errf[16:0];
				clipped_q <= over;
			end
			S_TAU: tau_q <= 27'(acc_sh10) + 27'(cor_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			joint_out_q <= joint_q;
			torque_q    <= res;
			clip_out_q  <= clipped_q && !byp_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign joint_out     = joint_out_q;
	assign torque_cmd    = torque_q;
	assign error_clipped = clip_out_q;

	`JITS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_acc, in_stall)
	`JITS_ASSERT_IMPLY(a_write_slot, clk, arst_n, mem_we, (state_q == S_CLIP) || (in_acc && cmd))
	`JITS_ASSERT_IMPLY(a_rate_limit, clk, arst_n, out_load, (res_delta <= lim28) && (res_delta >= -lim28))
	`JITS_ASSERT_IMPLY(a_bypass_unclipped, clk, arst_n, out_load && byp_q, !clipped_q)

endmodule
